>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the fin mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FMM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fin mixer assertion failed");

`define FMM_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fin mixer reset assertion failed");

`else

`define FMM_ASSERT(lbl, clk, rst_n, prop)

`define FMM_ASSERT_RST(lbl, clk, prop)

`endif

`endif

>>> sv/fmm_pkg.sv
// ----------------------------------------------------------------------------
// Fin moment mixer package
// Types, register codes and the throttle compensation table.
// ----------------------------------------------------------------------------
`default_nettype none

package fmm_pkg;

	localparam int CompHigh = 17454;
	localparam int CompLow  = 13171;
	localparam int ThrLow   = 153;
	localparam int ThrSpan  = 102;
	localparam int PulseBase = 900;
	localparam int NumFins  = 4;

	typedef enum logic [2:0] {
		REG_HOME_1      = 3'd0,
		REG_HOME_2      = 3'd1,
		REG_HOME_3      = 3'd2,
		REG_HOME_4      = 3'd3,
		REG_DEFLECT_MIN = 3'd4,
		REG_DEFLECT_MAX = 3'd5,
		REG_MOMENT_GAIN = 3'd6
	} cfg_reg_t;

	typedef logic [14:0] comp_tab_t [0:ThrSpan];

	function automatic comp_tab_t build_comp_tab();
		comp_tab_t tab;
		for (int i = 0; i <= ThrSpan; i++) begin
			tab[i] = 15'(CompHigh - ((CompHigh - CompLow) * i + ThrSpan / 2) / ThrSpan);
		end
		return tab;
	endfunction

	localparam comp_tab_t CompTab = build_comp_tab();

	typedef struct packed {
		logic [NumFins-1:0][6:0] home;
		logic signed [6:0]       dmin;
		logic [5:0]              dmax;
		logic signed [15:0]      gain;
	} cfg_t;

	typedef struct packed {
		logic                    kind;
		logic signed [11:0]      roll;
		logic signed [11:0]      pitch;
		logic signed [11:0]      yaw;
		logic [7:0]              throttle;
		logic [NumFins-1:0][7:0] direct;
	} in_t;

	typedef struct packed {
		logic                    kind;
		logic signed [11:0]      roll;
		logic signed [11:0]      pitch;
		logic signed [11:0]      yaw;
		logic [14:0]             comp;
		logic [NumFins-1:0][7:0] direct;
	} s1_t;

	typedef struct packed {
		logic                    kind;
		logic signed [11:0]      roll;
		logic signed [11:0]      pitch;
		logic signed [11:0]      yaw;
		logic signed [31:0]      k;
		logic [NumFins-1:0][7:0] direct;
	} s2_t;

	typedef struct packed {
		logic                    kind;
		logic signed [43:0]      prod_r;
		logic signed [43:0]      prod_p;
		logic signed [43:0]      prod_y;
		logic [NumFins-1:0][7:0] direct;
	} s3_t;

	typedef logic [NumFins-1:0][7:0]  defl_t;
	typedef logic [NumFins-1:0][11:0] pulse_t;

endpackage

`default_nettype wire

>>> sv/fmm_comp.sv
// ----------------------------------------------------------------------------
// Throttle compensation stage
// Clamps the throttle and looks up the Q1.14 compensation factor.
// ----------------------------------------------------------------------------
`default_nettype none

module fmm_comp (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         vld_in,
	input  wire fmm_pkg::in_t item_in,
	output logic              vld_s1,
	output fmm_pkg::s1_t      item_s1
);
	import fmm_pkg::*;

	logic [6:0] tab_idx;

	always_comb begin
		if (item_in.throttle < 8'(ThrLow)) begin
			tab_idx = '0;
		end else begin
			tab_idx = 7'(item_in.throttle - 8'(ThrLow));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.kind   <= item_in.kind;
			item_s1.roll   <= item_in.roll;
			item_s1.pitch  <= item_in.pitch;
			item_s1.yaw    <= item_in.yaw;
			item_s1.comp   <= CompTab[tab_idx];
			item_s1.direct <= item_in.direct;
		end
	end

endmodule

`default_nettype wire

>>> sv/fmm_scale.sv
// ----------------------------------------------------------------------------
// Moment scaling stages
// Forms gain times compensation, then scales each moment by it.
// ----------------------------------------------------------------------------
`default_nettype none

module fmm_scale (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         adv,
	input  wire logic signed [15:0] gain,
	input  wire logic               vld_s1,
	input  wire fmm_pkg::s1_t       item_s1,
	output logic                    vld_s2,
	output logic                    vld_s3,
	output fmm_pkg::s3_t            item_s3
);
	import fmm_pkg::*;

	s2_t                item_s2;
	logic signed [15:0] comp_sx;
	logic signed [31:0] k_prod;
	logic signed [43:0] pr_r;
	logic signed [43:0] pr_p;
	logic signed [43:0] pr_y;

	assign comp_sx = $signed({1'b0, item_s1.comp});
	assign k_prod  = gain * comp_sx;
	assign pr_r    = item_s2.k * item_s2.roll;
	assign pr_p    = item_s2.k * item_s2.pitch;
	assign pr_y    = item_s2.k * item_s2.yaw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv[0]) begin
				vld_s2 <= vld_s1;
			end
			if (adv[1]) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			item_s2.kind   <= item_s1.kind;
			item_s2.roll   <= item_s1.roll;
			item_s2.pitch  <= item_s1.pitch;
			item_s2.yaw    <= item_s1.yaw;
			item_s2.k      <= k_prod;
			item_s2.direct <= item_s1.direct;
		end
		if (adv[1]) begin
			item_s3.kind   <= item_s2.kind;
			item_s3.prod_r <= pr_r;
			item_s3.prod_p <= pr_p;
			item_s3.prod_y <= pr_y;
			item_s3.direct <= item_s2.direct;
		end
	end

endmodule

`default_nettype wire

>>> sv/fmm_mix.sv
// ----------------------------------------------------------------------------
// Fin mixing stage
// Truncates the scaled moments, mixes them into four fins and saturates; direct items pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module fmm_mix (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         vld_s3,
	input  wire fmm_pkg::s3_t item_s3,
	output logic              vld_s4,
	output fmm_pkg::defl_t    defl_s4
);
	import fmm_pkg::*;

	function automatic logic signed [20:0] trunc_shr(
		input logic signed [43:0] p,
		input logic [4:0]         sh
	);
		logic signed [43:0] bias;
		logic signed [43:0] q;
		bias = p[43] ? ((44'sd1 <<< sh) - 44'sd1) : 44'sd0;
		q    = (p + bias) >>> sh;
		return q[20:0];
	endfunction

	function automatic logic [7:0] sat8(input logic signed [21:0] v);
		logic [7:0] res;
		if (v < -22'sd128) begin
			res = 8'h80;
		end else if (v > 22'sd127) begin
			res = 8'h7F;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	logic signed [20:0] r_val;
	logic signed [20:0] p_val;
	logic signed [20:0] y_val;
	logic signed [21:0] r_x;
	logic signed [21:0] p_x;
	logic signed [21:0] y_x;
	defl_t              defl_next;

	always_comb begin
		r_val = trunc_shr(item_s3.prod_r, 5'd22);
		p_val = trunc_shr(item_s3.prod_p, 5'd22);
		y_val = trunc_shr(item_s3.prod_y, 5'd23);
		r_x   = 22'(r_val);
		p_x   = 22'(p_val);
		y_x   = 22'(y_val);
		if (item_s3.kind) begin
			defl_next = item_s3.direct;
		end else begin
			defl_next[0] = sat8(r_x + y_x);
			defl_next[1] = sat8(p_x + y_x);
			defl_next[2] = sat8(y_x - r_x);
			defl_next[3] = sat8(y_x - p_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			defl_s4 <= defl_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/fmm_servo.sv
// ----------------------------------------------------------------------------
// Servo output stage
// Adds home, clamps to the deflection window and forms pulse widths.
// ----------------------------------------------------------------------------
`default_nettype none

module fmm_servo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire fmm_pkg::cfg_t  cfg,
	input  wire logic           vld_s4,
	input  wire fmm_pkg::defl_t defl_s4,
	output logic                vld_s5,
	output fmm_pkg::pulse_t     pulse_s5
);
	import fmm_pkg::*;

	pulse_t pulse_next;

	always_comb begin
		logic signed [9:0]  home_x;
		logic signed [9:0]  theta;
		logic signed [9:0]  lo;
		logic signed [9:0]  hi;
		logic signed [12:0] t13;
		logic signed [12:0] pw;
		for (int i = 0; i < NumFins; i++) begin
			home_x = $signed({3'b000, cfg.home[i]});
			theta  = $signed({{2{defl_s4[i][7]}}, defl_s4[i]}) + home_x;
			lo     = home_x + 10'(cfg.dmin);
			hi     = home_x + $signed({4'b0000, cfg.dmax});
			if (theta < lo) begin
				theta = lo;
			end else if (theta > hi) begin
				theta = hi;
			end
			t13 = 13'(theta);
			pw  = (t13 <<< 3) + (t13 <<< 1) + 13'(PulseBase);
			pulse_next[i] = pw[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pulse_s5 <= pulse_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/fin_moment_mixer_servo_pulse_unit.sv
// ----------------------------------------------------------------------------
// Fin moment mixer servo pulse unit
// Pipeline: five register stages from item accept to result valid.
// Throughput: one item per cycle while out_stall is low; a stage advances when
// it is empty or the stage after it advances, so bubbles close up under stall.
// Reset: arst_n clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fin_moment_mixer_servo_pulse_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic signed [11:0] moment_roll,
	input  wire logic signed [11:0] moment_pitch,
	input  wire logic signed [11:0] moment_yaw,
	input  wire logic [7:0]  throttle_level,
	input  wire logic signed [7:0] direct_angle_1,
	input  wire logic signed [7:0] direct_angle_2,
	input  wire logic signed [7:0] direct_angle_3,
	input  wire logic signed [7:0] direct_angle_4,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      pulse_width_1,
	output logic [11:0]      pulse_width_2,
	output logic [11:0]      pulse_width_3,
	output logic [11:0]      pulse_width_4
);
	import fmm_pkg::*;

	cfg_t   cfg_q;
	in_t    item_in;
	s1_t    item_s1;
	s3_t    item_s3;
	defl_t  defl_s4;
	pulse_t pulse_s5;
	logic   vld_s1;
	logic   vld_s2;
	logic   vld_s3;
	logic   vld_s4;
	logic   vld_s5;
	logic   adv1;
	logic   adv2;
	logic   adv3;
	logic   adv4;
	logic   adv5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home <= {NumFins{7'd60}};
			cfg_q.dmin <= -7'sd30;
			cfg_q.dmax <= 6'd30;
			cfg_q.gain <= 16'sd256;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_HOME_1:      cfg_q.home[0] <= wr_data[6:0];
				REG_HOME_2:      cfg_q.home[1] <= wr_data[6:0];
				REG_HOME_3:      cfg_q.home[2] <= wr_data[6:0];
				REG_HOME_4:      cfg_q.home[3] <= wr_data[6:0];
				REG_DEFLECT_MIN: cfg_q.dmin    <= $signed(wr_data[6:0]);
				REG_DEFLECT_MAX: cfg_q.dmax    <= wr_data[5:0];
				REG_MOMENT_GAIN: cfg_q.gain    <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	assign adv5     = !vld_s5 || !out_stall;
	assign adv4     = !vld_s4 || adv5;
	assign adv3     = !vld_s3 || adv4;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_stall = !adv1;

	always_comb begin
		item_in.kind      = kind;
		item_in.roll      = moment_roll;
		item_in.pitch     = moment_pitch;
		item_in.yaw       = moment_yaw;
		item_in.throttle  = throttle_level;
		item_in.direct[0] = direct_angle_1;
		item_in.direct[1] = direct_angle_2;
		item_in.direct[2] = direct_angle_3;
		item_in.direct[3] = direct_angle_4;
	end

	fmm_comp u_comp (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv1),
		.vld_in  (in_valid),
		.item_in (item_in),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1)
	);

	fmm_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     ({adv3, adv2}),
		.gain    (cfg_q.gain),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1),
		.vld_s2  (vld_s2),
		.vld_s3  (vld_s3),
		.item_s3 (item_s3)
	);

	fmm_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv4),
		.vld_s3  (vld_s3),
		.item_s3 (item_s3),
		.vld_s4  (vld_s4),
		.defl_s4 (defl_s4)
	);

	fmm_servo u_servo (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv5),
		.cfg      (cfg_q),
		.vld_s4   (vld_s4),
		.defl_s4  (defl_s4),
		.vld_s5   (vld_s5),
		.pulse_s5 (pulse_s5)
	);

	assign out_valid     = vld_s5;
	assign pulse_width_1 = pulse_s5[0];
	assign pulse_width_2 = pulse_s5[1];
	assign pulse_width_3 = pulse_s5[2];
	assign pulse_width_4 = pulse_s5[3];

	`FMM_ASSERT(a_stall_only_when_full, clk, arst_n, in_stall |-> (out_valid && out_stall))
	`FMM_ASSERT(a_accept_fills_s1, clk, arst_n, (in_valid && !in_stall) |=> vld_s1)
	`FMM_ASSERT(a_pulse_range, clk, arst_n, out_valid |-> (pulse_width_1 >= 12'd260 && pulse_width_1 <= 12'd2800))
	`FMM_ASSERT_RST(a_reset_empty, clk, !arst_n |=> !out_valid)

endmodule

`default_nettype wire

>>> bench/fmm_checker.sv
// ----------------------------------------------------------------------------
// Fin mixer result checker
// Watches the register port and both item channels of the fin mixer. It keeps
// its own copy of the registers, predicts the four servo pulse widths of each
// accepted item and compares every delivered result, fin by fin, with the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module fmm_checker
	import fmm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [2:0]        wr_index,
	input  wire logic [15:0]       wr_data,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              kind,
	input  wire logic signed [11:0] moment_roll,
	input  wire logic signed [11:0] moment_pitch,
	input  wire logic signed [11:0] moment_yaw,
	input  wire logic [7:0]        throttle_level,
	input  wire logic signed [7:0] direct_angle_1,
	input  wire logic signed [7:0] direct_angle_2,
	input  wire logic signed [7:0] direct_angle_3,
	input  wire logic signed [7:0] direct_angle_4,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [11:0]       pulse_width_1,
	input  wire logic [11:0]       pulse_width_2,
	input  wire logic [11:0]       pulse_width_3,
	input  wire logic [11:0]       pulse_width_4,
	output int                     fail_count,
	output int                     pending,
	output int                     items_seen,
	output int                     mixed_seen,
	output int                     results_seen
);

	localparam int DegStep = 10;

	cfg_t   servo_cfg;
	pulse_t expected_pulses [$];
	int     errs;
	int     n_items;
	int     n_mixed;
	int     n_results;

	function automatic longint scale_toward_zero(longint p, int sh);
		return (p < 0) ? -((-p) >>> sh) : (p >>> sh);
	endfunction

	function automatic pulse_t predict_pulses(cfg_t c, in_t s);
		longint tq;
		longint comp;
		longint k;
		longint roll_d;
		longint pitch_d;
		longint yaw_d;
		longint defl [4];
		longint theta;
		longint lo;
		longint hi;
		pulse_t pw;
		if (s.kind == 1'b0) begin
			tq = (s.throttle < ThrLow) ? ThrLow : s.throttle;
			comp = CompHigh - ((CompHigh - CompLow) * (tq - ThrLow) + ThrSpan / 2) / ThrSpan;
			k = longint'($signed(c.gain)) * comp;
			roll_d = scale_toward_zero(k * longint'($signed(s.roll)), 22);
			pitch_d = scale_toward_zero(k * longint'($signed(s.pitch)), 22);
			yaw_d = scale_toward_zero(k * longint'($signed(s.yaw)), 23);
			defl[0] = roll_d + yaw_d;
			defl[1] = pitch_d + yaw_d;
			defl[2] = -roll_d + yaw_d;
			defl[3] = -pitch_d + yaw_d;
		end else begin
			for (int i = 0; i < 4; i++) begin
				defl[i] = longint'($signed(s.direct[i]));
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (defl[i] < -128) defl[i] = -128;
			if (defl[i] > 127) defl[i] = 127;
			lo = longint'(c.home[i]) + longint'($signed(c.dmin));
			hi = longint'(c.home[i]) + longint'(c.dmax);
			theta = defl[i] + longint'(c.home[i]);
			if (theta < lo) theta = lo;
			else if (theta > hi) theta = hi;
			pw[i] = 12'(theta * DegStep + PulseBase);
		end
		return pw;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		in_t    sample;
		pulse_t got;
		pulse_t want;
		if (!arst_n) begin
			servo_cfg.home <= {4{7'd60}};
			servo_cfg.dmin <= -7'sd30;
			servo_cfg.dmax <= 6'd30;
			servo_cfg.gain <= 16'sd256;
			expected_pulses.delete();
			errs = 0;
			n_items = 0;
			n_mixed = 0;
			n_results = 0;
			fail_count <= 0;
			pending <= 0;
			items_seen <= 0;
			mixed_seen <= 0;
			results_seen <= 0;
		end else begin
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_HOME_1: servo_cfg.home[0] <= wr_data[6:0];
					REG_HOME_2: servo_cfg.home[1] <= wr_data[6:0];
					REG_HOME_3: servo_cfg.home[2] <= wr_data[6:0];
					REG_HOME_4: servo_cfg.home[3] <= wr_data[6:0];
					REG_DEFLECT_MIN: servo_cfg.dmin <= wr_data[6:0];
					REG_DEFLECT_MAX: servo_cfg.dmax <= wr_data[5:0];
					REG_MOMENT_GAIN: servo_cfg.gain <= wr_data;
					default: ;
				endcase
			end
			// retire before predicting so a stray result never meets a fresh item
			if (out_valid && !out_stall) begin
				got[0] = pulse_width_1;
				got[1] = pulse_width_2;
				got[2] = pulse_width_3;
				got[3] = pulse_width_4;
				n_results++;
				if (expected_pulses.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("result with nothing expected: %0d %0d %0d %0d",
							got[0], got[1], got[2], got[3]);
				end else begin
					want = expected_pulses.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (got[i] !== want[i]) begin
							errs++;
							if (errs <= 10)
								$display("result %0d fin %0d: expected pulse %0d, got %0d",
									n_results, i + 1, want[i], got[i]);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				sample.kind = kind;
				sample.roll = moment_roll;
				sample.pitch = moment_pitch;
				sample.yaw = moment_yaw;
				sample.throttle = throttle_level;
				sample.direct[0] = direct_angle_1;
				sample.direct[1] = direct_angle_2;
				sample.direct[2] = direct_angle_3;
				sample.direct[3] = direct_angle_4;
				expected_pulses.push_back(predict_pulses(servo_cfg, sample));
				n_items++;
				if (!kind) n_mixed++;
			end
			fail_count <= errs;
			pending <= expected_pulses.size();
			items_seen <= n_items;
			mixed_seen <= n_mixed;
			results_seen <= n_results;
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Fin mixer regression
// Drives the fin mixer through directed and random items under several
// register settings, with random gaps on the input side and random output
// stalls. The checker beside the block predicts and compares every result;
// this module makes stimulus, guards against a hang and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import fmm_pkg::*;

	localparam int StallLimit = 1000;
	localparam int PhaseItems = 92;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              wr_en = 1'b0;
	logic [2:0]        wr_index = REG_HOME_1;
	logic [15:0]       wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              kind = 1'b0;
	logic signed [11:0] moment_roll = '0;
	logic signed [11:0] moment_pitch = '0;
	logic signed [11:0] moment_yaw = '0;
	logic [7:0]        throttle_level = '0;
	logic signed [7:0] direct_angle_1 = '0;
	logic signed [7:0] direct_angle_2 = '0;
	logic signed [7:0] direct_angle_3 = '0;
	logic signed [7:0] direct_angle_4 = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [11:0]       pulse_width_1;
	logic [11:0]       pulse_width_2;
	logic [11:0]       pulse_width_3;
	logic [11:0]       pulse_width_4;

	int fail_count;
	int pending;
	int items_seen;
	int mixed_seen;
	int results_seen;
	int settings_run = 1;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	fin_moment_mixer_servo_pulse_unit dut (.*);

	fmm_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 33);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_t mixed_sample(int roll, int pitch, int yaw, int thr);
		in_t s;
		s.kind = 1'b0;
		s.roll = 12'(roll);
		s.pitch = 12'(pitch);
		s.yaw = 12'(yaw);
		s.throttle = 8'(thr);
		for (int i = 0; i < 4; i++) s.direct[i] = 8'($urandom);
		return s;
	endfunction

	function automatic in_t direct_sample(int a1, int a2, int a3, int a4);
		in_t s;
		s.kind = 1'b1;
		s.roll = 12'($urandom);
		s.pitch = 12'($urandom);
		s.yaw = 12'($urandom);
		s.throttle = 8'($urandom);
		s.direct[0] = 8'(a1);
		s.direct[1] = 8'(a2);
		s.direct[2] = 8'(a3);
		s.direct[3] = 8'(a4);
		return s;
	endfunction

	function automatic in_t random_sample();
		in_t s;
		s = direct_sample($urandom, $urandom, $urandom, $urandom);
		s.kind = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1)) begin
			s.roll = 12'($urandom_range(0, 300)) - 12'd150;
			s.pitch = 12'($urandom_range(0, 300)) - 12'd150;
			s.yaw = 12'($urandom_range(0, 300)) - 12'd150;
		end
		return s;
	endfunction

	function automatic cfg_t fixed_setting(int h1, int h2, int h3, int h4,
			int dmin, int dmax, int gain);
		cfg_t c;
		c.home[0] = 7'(h1);
		c.home[1] = 7'(h2);
		c.home[2] = 7'(h3);
		c.home[3] = 7'(h4);
		c.dmin = 7'(dmin);
		c.dmax = 6'(dmax);
		c.gain = 16'(gain);
		return c;
	endfunction

	function automatic cfg_t random_setting();
		cfg_t c;
		for (int i = 0; i < 4; i++) c.home[i] = 7'($urandom_range(0, 120));
		c.dmin = -7'($urandom_range(0, 60));
		c.dmax = 6'($urandom_range(0, 60));
		if ($urandom_range(0, 1))
			c.gain = 16'($urandom_range(0, 1024)) - 16'd512;
		else
			c.gain = 16'($urandom);
		return c;
	endfunction

	task automatic offer_sample(input in_t s);
		while (!steady && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= s.kind;
		moment_roll <= s.roll;
		moment_pitch <= s.pitch;
		moment_yaw <= s.yaw;
		throttle_level <= s.throttle;
		direct_angle_1 <= s.direct[0];
		direct_angle_2 <= s.direct[1];
		direct_angle_3 <= s.direct[2];
		direct_angle_4 <= s.direct[3];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	task automatic program_setting(input cfg_t c);
		write_reg(REG_HOME_1, 16'(c.home[0]));
		write_reg(REG_HOME_2, 16'(c.home[1]));
		write_reg(REG_HOME_3, 16'(c.home[2]));
		write_reg(REG_HOME_4, 16'(c.home[3]));
		write_reg(REG_DEFLECT_MIN, 16'(c.dmin));
		write_reg(REG_DEFLECT_MAX, 16'(c.dmax));
		write_reg(REG_MOMENT_GAIN, c.gain);
		wr_en <= 1'b0;
		@(posedge clk);
		settings_run++;
	endtask

	task automatic random_phase();
		repeat (PhaseItems) offer_sample(random_sample());
		drain_pipeline();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: throttle knee, truncation, saturation, unused fields
		offer_sample(mixed_sample(0, 0, 0, 0));
		offer_sample(mixed_sample(10, -20, 6, 152));
		offer_sample(mixed_sample(10, -20, 6, 153));
		offer_sample(mixed_sample(10, -20, 6, 255));
		offer_sample(mixed_sample(5, 5, 5, 204));
		offer_sample(mixed_sample(-7, 7, -3, 180));
		offer_sample(mixed_sample(20, -25, 1, 0));
		offer_sample(mixed_sample(2047, 2047, 2047, 255));
		offer_sample(mixed_sample(-2048, -2048, -2048, 153));
		offer_sample(mixed_sample(2047, -2048, 0, 100));
		offer_sample(mixed_sample(100, -100, 300, 255));
		offer_sample(direct_sample(127, -128, 0, -1));
		offer_sample(direct_sample(-128, 127, 1, 0));
		offer_sample(direct_sample(30, -30, 31, -31));
		offer_sample(direct_sample(29, -29, 0, 0));
		offer_sample(direct_sample(100, -100, 60, -60));
		drain_pipeline();

		program_setting(fixed_setting(0, 120, 60, 33, -60, 60, 256));
		offer_sample(mixed_sample(60, -60, 0, 255));
		offer_sample(direct_sample(-128, 127, -60, 60));
		random_phase();

		steady = 1'b1;
		program_setting(fixed_setting(120, 120, 120, 120, 0, 0, 32767));
		random_phase();
		steady = 1'b0;

		program_setting(fixed_setting(127, 0, 127, 64, -64, 63, -32768));
		random_phase();

		// lower limit above upper limit
		program_setting(fixed_setting(60, 10, 100, 0, 40, 5, -300));
		random_phase();

		program_setting(random_setting());
		random_phase();
		program_setting(random_setting());
		random_phase();

		$display("Checked %0d results from %0d items (%0d mixed, %0d direct) over %0d settings,",
			results_seen, items_seen, mixed_seen, items_seen - mixed_seen, settings_run);
		$display("with throttle knee, int8 saturation, crossed and out-of-range limits.");
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
